@@ hdl/sorted_event_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_event_queue_core_macros.svh
// Assertion macros used by the sorted event queue core. All macros expect
// signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_CORE_MACROS_SVH
`define SORTED_EVENT_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH
// condition must hold at every clock edge out of reset
`define SEQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// same-cycle implication
`define SEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEQ_ASSERT_ALWAYS(lbl, cond, msg)
`define SEQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/seq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_pkg
// Types and codes shared by the sorted event queue core and its cells.
// ----------------------------------------------------------------------------
package seq_pkg;

  // request codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_POPPED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_END      = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // one queued event
  typedef struct packed {
    logic [31:0]        ev_time;
    logic signed [7:0]  prio;
    logic [15:0]        tag;
  } entry_t;

  // per-cycle operation applied to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  // command broadcast along the chain
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

  // input transaction
  typedef struct packed {
    logic               func;
    logic [31:0]        event_time;
    logic signed [7:0]  event_priority;
    logic [15:0]        event_tag;
  } in_item_t;

  // result transaction
  typedef struct packed {
    status_t            status;
    logic [31:0]        out_time;
    logic signed [7:0]  out_priority;
    logic [15:0]        out_tag;
    logic [31:0]        now_time;
    logic [4:0]         occupancy;
  } out_item_t;

endpackage

@@ hdl/seq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_cell
// One compare-and-shift cell of the sorted event chain. Holds one entry,
// flags whether the new event belongs ahead of it, and shifts right on
// insert or left on pop.
// ----------------------------------------------------------------------------
module seq_cell (
  input  logic               clk,
  input  seq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               left_gb,
  input  seq_pkg::entry_t    left_ent,
  input  seq_pkg::entry_t    right_ent,
  output seq_pkg::entry_t    ent,
  output logic               gb
);
  import seq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // new event goes before this entry (empty cells always accept)
  assign gb = !occupied
              || (ent_r.ev_time > cmd.ent.ev_time)
              || ((ent_r.ev_time == cmd.ent.ev_time) && (ent_r.prio < cmd.ent.prio));

  // next entry: first displaced cell takes the new event, later ones shift right
  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (gb) begin
          ent_nxt = left_gb ? left_ent : cmd.ent;
        end
      end
      CELL_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

@@ hdl/sorted_event_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_event_queue_core
// Event queue kept sorted by time (higher priority first on equal time,
// arrival order on full ties) in a chain of compare-and-shift cells.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_item_t (insert or pop)
//   out_    | output    | out_valid / out_ready | out_item_t (one per request)
//   cfg_    | input     | cfg_wr_en             | stop time, 32 bits
//
// Every cell compares the new event with its own entry and shifts in the
// same cycle, so one request per clock is taken while the output register
// is free or being drained.
// The result appears in the output register the cycle after acceptance.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n, synchronous) empties the queue, zeroes the current time and
// sets the stop time to all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_event_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  seq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output seq_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import seq_pkg::*;

  localparam int                 CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [31:0]      stop_time_r;
  logic             out_valid_r;
  out_item_t        out_data_r, res;

  cell_cmd_t        cmd;
  entry_t           cell_ent [QUEUE_DEPTH];
  logic             cell_gb  [QUEUE_DEPTH];
  entry_t           head;
  entry_t           new_ent;

  logic             accept, is_pop, full, empty, end_hit;
  logic [CNT_W+4:0] occ_ext;

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_pop  = (in_data.func == FUNC_POP);
  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);
  assign head    = cell_ent[0];
  assign end_hit = (stop_time_r <= head.ev_time);

  assign new_ent.ev_time = in_data.event_time;
  assign new_ent.prio    = in_data.event_priority;
  assign new_ent.tag     = in_data.event_tag;

  // request decode
  always_comb begin
    cmd.op           = CELL_HOLD;
    cmd.ent          = new_ent;
    count_nxt        = count_r;
    now_nxt          = now_r;
    res.status       = ST_INSERTED;
    res.out_time     = '0;
    res.out_priority = '0;
    res.out_tag      = '0;
    if (!is_pop) begin
      if (full) begin
        res.status = ST_FULL;
      end else begin
        cmd.op    = accept ? CELL_INSERT : CELL_HOLD;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (empty) begin
      res.status = ST_EMPTY;
    end else begin
      now_nxt          = head.ev_time;
      res.out_time     = head.ev_time;
      res.out_priority = head.prio;
      res.out_tag      = head.tag;
      if (end_hit) begin
        res.status = ST_END;
      end else begin
        res.status = ST_POPPED;
        cmd.op     = accept ? CELL_POP : CELL_HOLD;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
    occ_ext       = {5'b0, count_nxt};
    res.now_time  = now_nxt;
    res.occupancy = occ_ext[4:0];
  end

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   occ;
    logic   lgb;
    entry_t lent;
    entry_t rent;

    assign occ  = (IDX < count_r);
    assign lgb  = (i == 0) ? 1'b0    : cell_gb[(i == 0) ? 0 : i - 1];
    assign lent = (i == 0) ? new_ent : cell_ent[(i == 0) ? 0 : i - 1];
    assign rent = (i == QUEUE_DEPTH - 1) ? cell_ent[i]
                                         : cell_ent[(i == QUEUE_DEPTH - 1) ? i : i + 1];

    seq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ),
      .left_gb   (lgb),
      .left_ent  (lent),
      .right_ent (rent),
      .ent       (cell_ent[i]),
      .gb        (cell_gb[i])
    );
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      now_r   <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      now_r   <= now_nxt;
    end
  end

  // stop time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_time_r <= '1;
    end else if (cfg_wr_en) begin
      stop_time_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

`include "sorted_event_queue_core_macros.svh"

  `SEQ_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_CNT, "fill count above depth")
  `SEQ_ASSERT_NEXT(a_insert_count, accept && !is_pop && !full, count_r == $past(count_r) + CNT_W'(1), "insert did not grow queue")
  `SEQ_ASSERT_IMPL(a_head_order, count_r >= CNT_W'(2), cell_ent[0].ev_time <= cell_ent[1].ev_time, "head entries out of time order")
  `SEQ_ASSERT_IMPL(a_end_now, out_valid_r && (out_data_r.status == ST_END), out_data_r.now_time == out_data_r.out_time, "end result time mismatch")
  `SEQ_ASSERT_NEXT(a_result_valid, accept, out_valid_r, "accepted transaction gave no result")

endmodule
